### src/rpn_pkg.sv
// Shared types and constants for the RPN stack evaluator.
`timescale 1ns / 1ps
package rpn_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int ACT_W       = 3;
    localparam int DEPTH_W     = 7;
    localparam int STAT_W      = 3;
    localparam int OUT_W       = DATA_W + DEPTH_W + STAT_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
    localparam int DIV_STEPS   = DATA_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [DATA_W-1:0] MOST_NEG  = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] MINUS_ONE = {DATA_W{1'b1}};

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH = 3'd0,
        ACT_ADD  = 3'd1,
        ACT_SUB  = 3'd2,
        ACT_MUL  = 3'd3,
        ACT_DIV  = 3'd4
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_UNDERFLOW = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_DIVZERO   = 3'd3,
        STAT_DIVOVF    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'd0,
        S_READ = 3'd1,
        S_EXEC = 3'd2,
        S_DIV  = 3'd3,
        S_DFIN = 3'd4
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic take_now;   // finish a token in the accept cycle
        logic capture;    // latch an operator token and read next-of-top
        logic exec;       // run add/sub/mul or check and start a divide
        logic div_step;   // one restoring divide step
        logic div_finish; // sign-fix quotient and finish
    } ctrl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic op_multi;   // incoming token is an operator with two operands
        logic div_go;     // latched divide is legal
        logic div_last;   // divider is on its final step
    } dp_status_t;

endpackage

### src/rpn_ctrl.sv
// Control state machine for the RPN stack evaluator.
`timescale 1ns / 1ps
module rpn_ctrl
    import rpn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t sts,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;
    logic   accept;
    logic   out_load;

    assign out_free = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && sts.op_multi)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = sts.div_go ? S_DIV : S_IDLE;
            end
            S_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = S_DFIN;
                end
            end
            S_DFIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        s_tready = 1'b0;
        cmd      = '0;
        out_load = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready     = out_free;
                cmd.take_now = accept && !sts.op_multi;
                cmd.capture  = accept && sts.op_multi;
                out_load     = accept && !sts.op_multi;
            end
            S_READ:
            begin
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                out_load = !sts.div_go;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            S_DFIN:
            begin
                cmd.div_finish = 1'b1;
                out_load       = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### src/rpn_dpath.sv
// Datapath: operand stack, top-of-stack cache, ALU, divider and result register.
`timescale 1ns / 1ps
module rpn_dpath
    import rpn_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [ACT_W-1:0]       in_action,
    input  logic [DATA_W-1:0]      in_value,
    input  logic                   in_last,
    input  ctrl_cmd_t              cmd,
    output dp_status_t             sts,
    output logic [OUT_TDATA_W-1:0] out_data,
    output logic                   out_last
);

    logic [DATA_W-1:0] mem [STACK_DEPTH];

    logic [SP_W-1:0]      sp_reg;
    logic [SP_W-1:0]      sp_next;
    logic [DATA_W-1:0]    tos_reg;
    logic [DATA_W-1:0]    tos_next;
    logic [DATA_W-1:0]    nos_reg;
    action_t              act_reg;
    logic                 last_reg;

    logic [DATA_W-1:0]    rem_reg;
    logic [DATA_W-1:0]    rem_next;
    logic [DATA_W-1:0]    quo_reg;
    logic [DATA_W-1:0]    quo_next;
    logic [DATA_W-1:0]    dvs_reg;
    logic [DATA_W-1:0]    dvs_next;
    logic                 neg_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;

    logic [DATA_W-1:0]    out_top_reg;
    logic [DATA_W-1:0]    out_top_next;
    logic [DEPTH_W-1:0]   out_depth_reg;
    logic [DEPTH_W-1:0]   out_depth_next;
    status_t              out_stat_reg;
    status_t              out_stat_next;
    logic                 out_last_reg;
    logic                 out_last_next;

    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [ADDR_W-1:0]    mem_raddr;

    logic                 full;
    logic                 empty;
    logic                 is_op;
    logic [DATA_W-1:0]    cur_top;
    logic [DATA_W-1:0]    alu_res;
    logic [DATA_W-1:0]    n_mag;
    logic [DATA_W-1:0]    t_mag;
    logic                 div_zero;
    logic                 div_ovf;
    logic [DATA_W:0]      rem_shift;
    logic [DATA_W:0]      trial;
    logic [DATA_W-1:0]    quo_signed;
    action_t              in_act;

    assign in_act    = action_t'(in_action);
    assign full      = (sp_reg == SP_W'(STACK_DEPTH));
    assign empty     = (sp_reg == '0);
    assign cur_top   = empty ? '0 : tos_reg;
    assign is_op     = (in_action >= ACT_W'(ACT_ADD)) && (in_action <= ACT_W'(ACT_DIV));
    assign mem_waddr = ADDR_W'(sp_reg - SP_W'(1));
    assign mem_raddr = ADDR_W'(sp_reg - SP_W'(2));

    assign n_mag    = nos_reg[DATA_W-1] ? (DATA_W'(0) - nos_reg) : nos_reg;
    assign t_mag    = tos_reg[DATA_W-1] ? (DATA_W'(0) - tos_reg) : tos_reg;
    assign div_zero = (tos_reg == '0);
    assign div_ovf  = (nos_reg == MOST_NEG) && (tos_reg == MINUS_ONE);

    assign rem_shift  = {rem_reg, quo_reg[DATA_W-1]};
    assign trial      = rem_shift - {1'b0, dvs_reg};
    assign quo_signed = neg_reg ? (DATA_W'(0) - quo_reg) : quo_reg;

    assign sts.op_multi = is_op && (sp_reg >= SP_W'(2));
    assign sts.div_go   = (act_reg == ACT_DIV) && !div_zero && !div_ovf;
    assign sts.div_last = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));

    always_comb
    begin
        case (act_reg)
            ACT_ADD: alu_res = nos_reg + tos_reg;
            ACT_SUB: alu_res = nos_reg - tos_reg;
            default: alu_res = nos_reg * tos_reg;
        endcase
    end

    always_comb
    begin
        sp_next        = sp_reg;
        tos_next       = tos_reg;
        mem_we         = 1'b0;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        dvs_next       = dvs_reg;
        cnt_next       = cnt_reg;
        out_top_next   = out_top_reg;
        out_depth_next = out_depth_reg;
        out_stat_next  = out_stat_reg;
        out_last_next  = out_last_reg;

        if (cmd.take_now)
        begin
            out_top_next   = cur_top;
            out_depth_next = DEPTH_W'(sp_reg);
            out_stat_next  = STAT_OK;
            out_last_next  = in_last;
            case (in_act)
                ACT_PUSH:
                begin
                    if (full)
                    begin
                        out_stat_next = STAT_FULL;
                    end
                    else
                    begin
                        // spill the cached top into the memory
                        mem_we         = !empty;
                        tos_next       = in_value;
                        sp_next        = sp_reg + SP_W'(1);
                        out_top_next   = in_value;
                        out_depth_next = DEPTH_W'(sp_reg + SP_W'(1));
                    end
                end
                ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV:
                begin
                    out_stat_next = STAT_UNDERFLOW;
                end
                default:
                begin
                end
            endcase
            if (in_last)
            begin
                sp_next = '0;
            end
        end

        if (cmd.exec)
        begin
            out_last_next  = last_reg;
            out_top_next   = tos_reg;
            out_depth_next = DEPTH_W'(sp_reg);
            out_stat_next  = STAT_OK;
            if (act_reg == ACT_DIV)
            begin
                if (div_zero)
                begin
                    out_stat_next = STAT_DIVZERO;
                end
                else if (div_ovf)
                begin
                    out_stat_next = STAT_DIVOVF;
                end
                rem_next = '0;
                quo_next = n_mag;
                dvs_next = t_mag;
                cnt_next = '0;
                if (!sts.div_go && last_reg)
                begin
                    sp_next = '0;
                end
            end
            else
            begin
                tos_next       = alu_res;
                out_top_next   = alu_res;
                out_depth_next = DEPTH_W'(sp_reg - SP_W'(1));
                sp_next        = last_reg ? '0 : (sp_reg - SP_W'(1));
            end
        end

        if (cmd.div_step)
        begin
            if (!trial[DATA_W])
            begin
                rem_next = trial[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + DIV_CNT_W'(1);
        end

        if (cmd.div_finish)
        begin
            tos_next       = quo_signed;
            out_top_next   = quo_signed;
            out_depth_next = DEPTH_W'(sp_reg - SP_W'(1));
            out_stat_next  = STAT_OK;
            sp_next        = last_reg ? '0 : (sp_reg - SP_W'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= tos_reg;
        end
        if (cmd.capture)
        begin
            nos_reg  <= mem[mem_raddr];
            act_reg  <= in_act;
            last_reg <= in_last;
        end
        if (cmd.exec)
        begin
            neg_reg <= nos_reg[DATA_W-1] ^ tos_reg[DATA_W-1];
        end
        tos_reg       <= tos_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        dvs_reg       <= dvs_next;
        cnt_reg       <= cnt_next;
        out_top_reg   <= out_top_next;
        out_depth_reg <= out_depth_next;
        out_stat_reg  <= out_stat_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg <= '0;
        end
        else
        begin
            sp_reg <= sp_next;
        end
    end

    assign out_data = {{(OUT_TDATA_W - OUT_W){1'b0}}, out_stat_reg, out_depth_reg, out_top_reg};
    assign out_last = out_last_reg;

endmodule

### src/rpn_stack_evaluator_unit.sv
// Top level of the RPN stack evaluator: controller plus datapath.
`timescale 1ns / 1ps
// Push, underflow and ignored tokens give their result in the cycle after the transaction;
//   add, subtract and multiply pass through stack read and execute; divide passes through
//   read, execute, the 32-step restoring divider that produces one quotient bit per cycle, and sign-fix.
// Tokens are handled one at a time; a new token is accepted only when idle and the result slot is free.
// Reset: rst_n (async, low) empties the stack and drops any pending result; stack memory
//   contents are not cleared and are never read before being written.
module rpn_stack_evaluator_unit
    import rpn_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // input token stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [DATA_W-1:0]      s_tdata,   // [31:0] push_value
    input  logic [ACT_W-1:0]       s_tuser,   // [2:0] action
    input  logic                   s_tlast,   // last_token
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [31:0] top_value, [38:32] stack_depth,
                                              // [41:39] status, [47:42] zero
    output logic                   m_tlast    // expression_done
);

    ctrl_cmd_t  cmd;
    dp_status_t sts;

    // Sequencer: owns the handshakes and steps the datapath through read,
    // execute and the divide iterations.
    rpn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Stack memory with the top entry cached in a register, so an operator
    // needs one memory read for the entry below the top.
    rpn_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_action (s_tuser),
        .in_value  (s_tdata),
        .in_last   (s_tlast),
        .cmd       (cmd),
        .sts       (sts),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule
